### design/bspn_pkg.sv
package bspn_pkg;

    // default fixed-point setup
    localparam int UV_FRAC_BITS_DEF  = 16;
    localparam int OUT_FRAC_BITS_DEF = 12;

    // port and field widths
    localparam int PARAM_W = 17;
    localparam int CFG_W   = 63;
    localparam int COORD_W = 7;
    localparam int POS_W   = 16;
    localparam int NORM_W  = 16;

    // configuration register indexes
    localparam int               CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NET_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NET_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NET_Z = 2'd2;

    // tangent / cross product datapath
    localparam int TAN_FRAC = 16;
    localparam int TAN_W    = 23;
    localparam int CROSS_W  = 2 * TAN_W;
    localparam int MAG_W    = CROSS_W;

    // normalization and length
    localparam int NRM_MSB  = 29;
    localparam int NRM_W    = NRM_MSB + 1;
    localparam int SQR_W    = 2 * NRM_W;
    localparam int LEN2_W   = SQR_W + 2;
    localparam int SQ_W     = LEN2_W + 1;
    localparam int ROOT_W   = LEN2_W / 2;
    localparam int NORM_LOG = 14;
    localparam int QUO_W    = NORM_LOG + 1;
    localparam int DIV_W    = ROOT_W + QUO_W;

    // leading-one search over the magnitude word
    localparam int CHUNK_W = 8;
    localparam int NCH     = (MAG_W + CHUNK_W - 1) / CHUNK_W;
    localparam int MSB_W   = $clog2(NCH * CHUNK_W);

    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_pos;

    // side info that rides along with the normal datapath
    typedef struct packed {
        t_pos       pos;
        logic [2:0] neg;
        logic       degen;
    } t_side;

endpackage

### design/bspn_fifo.sv
module bspn_fifo #(
    parameter  int W     = 8,
    parameter  int DEPTH = bspn_pkg::FIFO_DEPTH,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic [CW-1:0] n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### design/bspn_front.sv
module bspn_front #(
    parameter  int UV_FRAC_BITS = bspn_pkg::UV_FRAC_BITS_DEF,
    localparam int F     = UV_FRAC_BITS,
    localparam int WW    = F + 2,
    localparam int DW    = F + 3,
    localparam int PW    = 3 * WW + 3 * DW,
    localparam int WTS_W = 2 * PW
) (
    input  logic [bspn_pkg::PARAM_W-1:0] i_param_u,
    input  logic [bspn_pkg::PARAM_W-1:0] i_param_v,
    output logic [WTS_W-1:0]             o_wts
);

    localparam int UW = (F + 1 > bspn_pkg::PARAM_W) ? F + 1 : bspn_pkg::PARAM_W;
    localparam int XW = 2 * UW + 1;
    localparam logic [UW-1:0] ONE  = UW'(1) << F;
    localparam logic [XW-1:0] HALF = XW'(1) << (F - 1);

    // Bernstein weights and derivative weights, u in the low half, v in the high half
    for (genvar g = 0; g < 2; g++) begin : g_par
        logic [UW-1:0] p;
        logic [UW-1:0] t;
        logic [UW-1:0] s;
        logic [XW-1:0] ss;
        logic [XW-1:0] ts2;
        logic [XW-1:0] tt;

        assign p   = (g == 0) ? UW'(i_param_u) : UW'(i_param_v);
        assign t   = (p > ONE) ? ONE : p;
        assign s   = ONE - t;
        assign ss  = XW'(s) * XW'(s) + HALF;
        assign ts2 = ((XW'(t) * XW'(s)) << 1) + HALF;
        assign tt  = XW'(t) * XW'(t) + HALF;

        assign o_wts[g*PW + 0*WW +: WW] = WW'(ss >> F);
        assign o_wts[g*PW + 1*WW +: WW] = WW'(ts2 >> F);
        assign o_wts[g*PW + 2*WW +: WW] = WW'(tt >> F);
        assign o_wts[g*PW + 3*WW + 0*DW +: DW] = -$signed(DW'({s[F:0], 1'b0}));
        assign o_wts[g*PW + 3*WW + 1*DW +: DW] =
            $signed(DW'({s[F:0], 1'b0})) - $signed(DW'({t[F:0], 1'b0}));
        assign o_wts[g*PW + 3*WW + 2*DW +: DW] = DW'({t[F:0], 1'b0});
    end

endmodule

### design/bspn_geom.sv
module bspn_geom #(
    parameter  int UV_FRAC_BITS  = bspn_pkg::UV_FRAC_BITS_DEF,
    parameter  int OUT_FRAC_BITS = bspn_pkg::OUT_FRAC_BITS_DEF,
    localparam int F     = UV_FRAC_BITS,
    localparam int WW    = F + 2,
    localparam int DW    = F + 3,
    localparam int PW    = 3 * WW + 3 * DW,
    localparam int WTS_W = 2 * PW
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_en,
    input  logic                                     i_valid,
    input  logic [WTS_W-1:0]                         i_wts,
    input  logic [bspn_pkg::CFG_W-1:0]               i_net_x,
    input  logic [bspn_pkg::CFG_W-1:0]               i_net_y,
    input  logic [bspn_pkg::CFG_W-1:0]               i_net_z,
    output logic                                     o_valid,
    output bspn_pkg::t_pos                           o_pos,
    output logic signed [bspn_pkg::CROSS_W-1:0]      o_cross [3]
);

    localparam int RWW  = F + 9;
    localparam int RDW  = F + 10;
    localparam int SW   = 2 * F + 12;
    localparam int PSH  = 2 * F + 4 - OUT_FRAC_BITS;
    localparam int TSH  = 2 * F + 4 - bspn_pkg::TAN_FRAC;
    localparam int TW   = bspn_pkg::TAN_W;
    localparam int CRW  = bspn_pkg::CROSS_W;
    localparam logic signed [SW:0] PHALF = (SW+1)'((SW+1)'(1) << PSH) >>> 1;
    localparam logic signed [SW:0] THALF = (SW+1)'((SW+1)'(1) << TSH) >>> 1;
    localparam logic signed [SW:0] PMAX  = (SW+1)'(32767);
    localparam logic signed [SW:0] PMIN  = -(SW+1)'(32768);

    function automatic logic signed [bspn_pkg::COORD_W-1:0] coord(
        input logic [bspn_pkg::CFG_W-1:0] net,
        input int                         k
    );
        return net[bspn_pkg::COORD_W*k +: bspn_pkg::COORD_W];
    endfunction

    logic [bspn_pkg::CFG_W-1:0] net [3];
    logic signed [WW-1:0] wu [3];
    logic signed [DW-1:0] du [3];
    logic signed [WW-1:0] wv [3];
    logic signed [DW-1:0] dv [3];

    logic signed [RWW-1:0] n_rw [3][3];
    logic signed [RDW-1:0] n_rd [3][3];
    logic signed [RWW-1:0] r_rw [3][3];
    logic signed [RDW-1:0] r_rd [3][3];
    logic signed [WW-1:0]  r_g1_wv [3];
    logic signed [DW-1:0]  r_g1_dv [3];

    logic signed [SW-1:0]  r_pw  [3][3];
    logic signed [SW-1:0]  r_psu [3][3];
    logic signed [SW-1:0]  r_psv [3][3];

    logic signed [bspn_pkg::POS_W-1:0] n_pos [3];
    logic signed [TW-1:0]  n_tu [3];
    logic signed [TW-1:0]  n_tv [3];
    logic signed [SW-1:0]  p_sum [3];
    logic signed [SW-1:0]  u_sum [3];
    logic signed [SW-1:0]  v_sum [3];
    logic signed [SW:0]    p_rnd [3];
    logic signed [SW:0]    u_rnd [3];
    logic signed [SW:0]    v_rnd [3];
    bspn_pkg::t_pos        r_g3_pos;
    logic signed [TW-1:0]  r_tu [3];
    logic signed [TW-1:0]  r_tv [3];

    bspn_pkg::t_pos        r_g4_pos;
    logic signed [CRW-1:0] r_pa [3];
    logic signed [CRW-1:0] r_pb [3];

    bspn_pkg::t_pos        r_g5_pos;
    logic signed [CRW-1:0] r_cr [3];

    logic [4:0] r_v;

    assign net[0] = i_net_x;
    assign net[1] = i_net_y;
    assign net[2] = i_net_z;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            wu[c] = i_wts[c*WW +: WW];
            du[c] = i_wts[3*WW + c*DW +: DW];
            wv[c] = i_wts[PW + c*WW +: WW];
            dv[c] = i_wts[PW + 3*WW + c*DW +: DW];
        end
    end

    // stage 1: row blends along u (col goes with u, row goes with v)
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int r = 0; r < 3; r++) begin
                n_rw[a][r] = '0;
                n_rd[a][r] = '0;
                for (int c = 0; c < 3; c++) begin
                    n_rw[a][r] = n_rw[a][r] + wu[c] * coord(net[a], r * 3 + c);
                    n_rd[a][r] = n_rd[a][r] + du[c] * coord(net[a], r * 3 + c);
                end
            end
        end
    end

    // stage 3: column sums, point rounding/saturation, tangent rounding
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            p_sum[a] = r_pw[a][0] + r_pw[a][1] + r_pw[a][2];
            u_sum[a] = r_psu[a][0] + r_psu[a][1] + r_psu[a][2];
            v_sum[a] = r_psv[a][0] + r_psv[a][1] + r_psv[a][2];
            p_rnd[a] = ($signed({p_sum[a][SW-1], p_sum[a]}) + PHALF) >>> PSH;
            u_rnd[a] = ($signed({u_sum[a][SW-1], u_sum[a]}) + THALF) >>> TSH;
            v_rnd[a] = ($signed({v_sum[a][SW-1], v_sum[a]}) + THALF) >>> TSH;
            if (p_rnd[a] > PMAX) begin
                n_pos[a] = 16'sh7fff;
            end else if (p_rnd[a] < PMIN) begin
                n_pos[a] = -16'sh8000;
            end else begin
                n_pos[a] = bspn_pkg::POS_W'(p_rnd[a]);
            end
            n_tu[a] = TW'(u_rnd[a]);
            n_tv[a] = TW'(v_rnd[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rw    <= n_rw;
            r_rd    <= n_rd;
            r_g1_wv <= wv;
            r_g1_dv <= dv;
            for (int a = 0; a < 3; a++) begin
                for (int r = 0; r < 3; r++) begin
                    r_pw[a][r]  <= r_g1_wv[r] * r_rw[a][r];
                    r_psu[a][r] <= r_g1_wv[r] * r_rd[a][r];
                    r_psv[a][r] <= r_g1_dv[r] * r_rw[a][r];
                end
            end
            r_g3_pos <= '{x: n_pos[0], y: n_pos[1], z: n_pos[2]};
            r_tu     <= n_tu;
            r_tv     <= n_tv;
            r_g4_pos <= r_g3_pos;
            r_pa[0]  <= r_tu[1] * r_tv[2];
            r_pb[0]  <= r_tu[2] * r_tv[1];
            r_pa[1]  <= r_tu[2] * r_tv[0];
            r_pb[1]  <= r_tu[0] * r_tv[2];
            r_pa[2]  <= r_tu[0] * r_tv[1];
            r_pb[2]  <= r_tu[1] * r_tv[0];
            r_g5_pos <= r_g4_pos;
            for (int a = 0; a < 3; a++) begin
                r_cr[a] <= r_pa[a] - r_pb[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    assign o_valid = r_v[4];
    assign o_pos   = r_g5_pos;
    assign o_cross = r_cr;

endmodule

### design/bspn_norm.sv
module bspn_norm (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  bspn_pkg::t_pos                       i_pos,
    input  logic signed [bspn_pkg::CROSS_W-1:0]  i_cross [3],
    output logic                                 o_valid,
    output bspn_pkg::t_pos                       o_pos,
    output logic signed [bspn_pkg::NORM_W-1:0]   o_norm [3],
    output logic                                 o_degen
);

    localparam int MW    = bspn_pkg::MAG_W;
    localparam int NW    = bspn_pkg::NRM_W;
    localparam int NCH   = bspn_pkg::NCH;
    localparam int CHW   = bspn_pkg::CHUNK_W;
    localparam int SBW   = bspn_pkg::MSB_W;
    localparam int RW    = bspn_pkg::ROOT_W;
    localparam int QW    = bspn_pkg::QUO_W;
    localparam int XW    = bspn_pkg::SQ_W;
    localparam int VW    = bspn_pkg::DIV_W;
    localparam int LBW   = $clog2(CHW);
    localparam logic [SBW-1:0] NMSB = SBW'(bspn_pkg::NRM_MSB);

    // N1: magnitudes, signs, zero test
    logic [MW-1:0]           r_n1_mag [3];
    bspn_pkg::t_side         r_n1_side;
    // N2: per-chunk leading one
    logic [NCH*CHW-1:0]      or_word;
    logic [NCH-1:0]          n_nz;
    logic [LBW-1:0]          n_lp [NCH];
    logic [NCH-1:0]          r_n2_nz;
    logic [LBW-1:0]          r_n2_lp [NCH];
    logic [MW-1:0]           r_n2_mag [3];
    bspn_pkg::t_side         r_n2_side;
    // N3: shift direction and amount
    logic [SBW-1:0]          msb;
    logic                    r_n3_right;
    logic [SBW-1:0]          r_n3_amt;
    logic [MW-1:0]           r_n3_mag [3];
    bspn_pkg::t_side         r_n3_side;
    // N4: normalized magnitudes
    logic [NW-1:0]           r_n4_nm [3];
    bspn_pkg::t_side         r_n4_side;
    // N5: squares
    logic [bspn_pkg::SQR_W-1:0] r_n5_sq [3];
    logic [NW-1:0]           r_n5_nm [3];
    bspn_pkg::t_side         r_n5_side;
    // square root pipeline, entry 0 loaded with the squared length
    logic [XW-1:0]           r_sq_x    [RW+1];
    logic [XW-1:0]           r_sq_res  [RW+1];
    logic [NW-1:0]           r_sq_nm   [RW+1][3];
    bspn_pkg::t_side         r_sq_side [RW+1];
    // divider pipeline, entry 0 loaded with rounded numerators
    logic [VW-1:0]           r_dv_rem  [QW+1][3];
    logic [QW-1:0]           r_dv_q    [QW+1][3];
    logic [RW-1:0]           r_dv_r    [QW+1];
    bspn_pkg::t_side         r_dv_side [QW+1];
    // output register
    bspn_pkg::t_pos          r_out_pos;
    logic signed [bspn_pkg::NORM_W-1:0] r_out_norm [3];
    logic                    r_out_degen;

    logic [4:0]              r_nv;
    logic [RW:0]             r_sq_v;
    logic [QW:0]             r_dv_v;
    logic                    r_out_v;

    assign or_word = (NCH*CHW)'(r_n1_mag[0] | r_n1_mag[1] | r_n1_mag[2]);

    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            n_nz[i] = |or_word[i*CHW +: CHW];
            n_lp[i] = '0;
            for (int b = 0; b < CHW; b++) begin
                if (or_word[i*CHW + b]) begin
                    n_lp[i] = LBW'(b);
                end
            end
        end
    end

    always_comb begin
        msb = '0;
        for (int i = 0; i < NCH; i++) begin
            if (r_n2_nz[i]) begin
                msb = SBW'(i * CHW) + SBW'(r_n2_lp[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r_n1_mag[a] <= i_cross[a][bspn_pkg::CROSS_W-1] ?
                               MW'(-i_cross[a]) : MW'(i_cross[a]);
                r_n1_side.neg[a] <= i_cross[a][bspn_pkg::CROSS_W-1];
            end
            r_n1_side.pos   <= i_pos;
            r_n1_side.degen <= (i_cross[0] == '0) && (i_cross[1] == '0) &&
                               (i_cross[2] == '0);

            r_n2_nz   <= n_nz;
            r_n2_lp   <= n_lp;
            r_n2_mag  <= r_n1_mag;
            r_n2_side <= r_n1_side;

            r_n3_right <= (msb > NMSB);
            r_n3_amt   <= (msb > NMSB) ? msb - NMSB : NMSB - msb;
            r_n3_mag   <= r_n2_mag;
            r_n3_side  <= r_n2_side;

            for (int a = 0; a < 3; a++) begin
                r_n4_nm[a] <= r_n3_right ? NW'(r_n3_mag[a] >> r_n3_amt) :
                                           NW'(r_n3_mag[a] << r_n3_amt);
            end
            r_n4_side <= r_n3_side;

            for (int a = 0; a < 3; a++) begin
                r_n5_sq[a] <= bspn_pkg::SQR_W'(r_n4_nm[a]) *
                              bspn_pkg::SQR_W'(r_n4_nm[a]);
            end
            r_n5_nm   <= r_n4_nm;
            r_n5_side <= r_n4_side;

            r_sq_x[0]    <= XW'(r_n5_sq[0]) + XW'(r_n5_sq[1]) + XW'(r_n5_sq[2]);
            r_sq_res[0]  <= '0;
            r_sq_nm[0]   <= r_n5_nm;
            r_sq_side[0] <= r_n5_side;
        end
    end

    // one result bit per stage, most significant first
    for (genvar i = 0; i < RW; i++) begin : g_sq
        localparam logic [XW-1:0] BIT = XW'(1) << (2 * (RW - 1 - i));
        logic [XW-1:0] trial;
        assign trial = r_sq_res[i] + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_sq_x[i] >= trial) begin
                    r_sq_x[i+1]   <= r_sq_x[i] - trial;
                    r_sq_res[i+1] <= (r_sq_res[i] >> 1) + BIT;
                end else begin
                    r_sq_x[i+1]   <= r_sq_x[i];
                    r_sq_res[i+1] <= r_sq_res[i] >> 1;
                end
                r_sq_nm[i+1]   <= r_sq_nm[i];
                r_sq_side[i+1] <= r_sq_side[i];
            end
        end
    end

    // numerator = mag * one + root / 2, so the quotient rounds to nearest
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r_dv_rem[0][a] <= (VW'(r_sq_nm[RW][a]) << bspn_pkg::NORM_LOG) +
                                  VW'(r_sq_res[RW][RW-1:1]);
                r_dv_q[0][a]   <= '0;
            end
            r_dv_r[0]    <= r_sq_res[RW][RW-1:0];
            r_dv_side[0] <= r_sq_side[RW];
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_dv
        localparam int B = QW - 1 - j;
        logic [VW-1:0] dsr;
        assign dsr = VW'(r_dv_r[j]) << B;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int a = 0; a < 3; a++) begin
                    if (r_dv_rem[j][a] >= dsr) begin
                        r_dv_rem[j+1][a] <= r_dv_rem[j][a] - dsr;
                        r_dv_q[j+1][a]   <= r_dv_q[j][a] | (QW'(1) << B);
                    end else begin
                        r_dv_rem[j+1][a] <= r_dv_rem[j][a];
                        r_dv_q[j+1][a]   <= r_dv_q[j][a];
                    end
                end
                r_dv_r[j+1]    <= r_dv_r[j];
                r_dv_side[j+1] <= r_dv_side[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                if (r_dv_side[QW].degen) begin
                    r_out_norm[a] <= '0;
                end else if (r_dv_side[QW].neg[a]) begin
                    r_out_norm[a] <= -$signed(bspn_pkg::NORM_W'(r_dv_q[QW][a]));
                end else begin
                    r_out_norm[a] <= $signed(bspn_pkg::NORM_W'(r_dv_q[QW][a]));
                end
            end
            r_out_pos   <= r_dv_side[QW].pos;
            r_out_degen <= r_dv_side[QW].degen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv    <= '0;
            r_sq_v  <= '0;
            r_dv_v  <= '0;
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_nv    <= {r_nv[3:0], i_valid};
            r_sq_v  <= {r_sq_v[RW-1:0], r_nv[4]};
            r_dv_v  <= {r_dv_v[QW-1:0], r_sq_v[RW]};
            r_out_v <= r_dv_v[QW];
        end
    end

    assign o_valid = r_out_v;
    assign o_pos   = r_out_pos;
    assign o_norm  = r_out_norm;
    assign o_degen = r_out_degen;

    // largest normalized magnitude must land in [2^29, 2^30)
    a_nrm_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nv[3] && !r_n4_side.degen |->
            (r_n4_nm[0][NW-1] || r_n4_nm[1][NW-1] || r_n4_nm[2][NW-1]))
        else $error("normalized magnitude out of window");

    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_v[RW] && !r_sq_side[RW].degen |-> (r_sq_res[RW][RW-1:RW-2] != '0))
        else $error("vector length below normalized floor");

    a_unit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degen |->
            (o_norm[0] != '0 || o_norm[1] != '0 || o_norm[2] != '0))
        else $error("zero normal without degenerate flag");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degen |->
            (o_norm[0] == '0 && o_norm[1] == '0 && o_norm[2] == '0))
        else $error("degenerate result carries a nonzero normal");

endmodule

### design/bezier_surface_point_normal_core.sv
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+--------------------------------------------
// in      | input     | i_valid / o_ready  | i_param_u, i_param_v (Q1.16 surface params)
// out     | output    | o_valid / i_ready  | o_pos_x/y/z, o_norm_x/y/z, o_degenerate
// cfg     | input     | i_cfg_we           | i_cfg_idx, i_cfg_data (packed control net)
//
// Throughput: one transaction per clock, sustained while i_ready stays high.
// Stages from input accept to o_valid: 1 queue, 5 geometry, 5 normalize, 32 square-root,
//   16 divider stages, 1 output register.
// The 31-step square root and the three 15-step dividers are fully pipelined, one
//   result bit per stage, and set the depth.
// Reset (i_rst_n low, synchronous) clears the control net, queue and all stage valids.
// A stall on the output freezes the whole back pipeline; the input queue keeps
//   accepting until it is full, so o_ready only drops under a sustained stall.
module bezier_surface_point_normal_core #(
    parameter  int UV_FRAC_BITS  = bspn_pkg::UV_FRAC_BITS_DEF,
    parameter  int OUT_FRAC_BITS = bspn_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input transactions
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [bspn_pkg::PARAM_W-1:0]        i_param_u,
    input  logic [bspn_pkg::PARAM_W-1:0]        i_param_v,
    // result transactions
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [bspn_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [bspn_pkg::POS_W-1:0]   o_pos_y,
    output logic signed [bspn_pkg::POS_W-1:0]   o_pos_z,
    output logic signed [bspn_pkg::NORM_W-1:0]  o_norm_x,
    output logic signed [bspn_pkg::NORM_W-1:0]  o_norm_y,
    output logic signed [bspn_pkg::NORM_W-1:0]  o_norm_z,
    output logic                                o_degenerate,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [bspn_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bspn_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int F     = UV_FRAC_BITS;
    localparam int PW    = 3 * (F + 2) + 3 * (F + 3);
    localparam int WTS_W = 2 * PW;

    // Control net: nine 7-bit signed Q2.4 points per axis, point (row,col) at 7*(3*row+col).
    logic [bspn_pkg::CFG_W-1:0] r_net_x;
    logic [bspn_pkg::CFG_W-1:0] r_net_y;
    logic [bspn_pkg::CFG_W-1:0] r_net_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_net_x <= '0;
            r_net_y <= '0;
            r_net_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bspn_pkg::CFG_NET_X: r_net_x <= i_cfg_data;
                bspn_pkg::CFG_NET_Y: r_net_y <= i_cfg_data;
                bspn_pkg::CFG_NET_Z: r_net_z <= i_cfg_data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // Front: clamp parameters and form Bernstein / derivative weights at accept time.
    logic [WTS_W-1:0] front_wts;
    logic             q_full;
    logic             q_valid;
    logic [WTS_W-1:0] q_wts;
    logic             in_fire;
    logic             back_en;

    assign o_ready = !q_full;
    assign in_fire = i_valid && o_ready;

    bspn_front #(
        .UV_FRAC_BITS (UV_FRAC_BITS)
    ) u_front (
        .i_param_u (i_param_u),
        .i_param_v (i_param_v),
        .o_wts     (front_wts)
    );

    // Short queue decouples the input handshake from the back pipeline stall.
    bspn_fifo #(
        .W     (WTS_W),
        .DEPTH (bspn_pkg::FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_fire),
        .i_data  (front_wts),
        .o_full  (q_full),
        .i_pop   (q_valid && back_en),
        .o_valid (q_valid),
        .o_data  (q_wts)
    );

    // Back pipeline advances whenever the output register is free or being drained.
    logic                                geo_valid;
    bspn_pkg::t_pos                      geo_pos;
    logic signed [bspn_pkg::CROSS_W-1:0] geo_cross [3];
    bspn_pkg::t_pos                      out_pos;
    logic signed [bspn_pkg::NORM_W-1:0]  out_norm [3];

    assign back_en = !o_valid || i_ready;

    // Geometry: point, tangents dS/du and dS/dv, cross product.
    bspn_geom #(
        .UV_FRAC_BITS  (UV_FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (back_en),
        .i_valid (q_valid),
        .i_wts   (q_wts),
        .i_net_x (r_net_x),
        .i_net_y (r_net_y),
        .i_net_z (r_net_z),
        .o_valid (geo_valid),
        .o_pos   (geo_pos),
        .o_cross (geo_cross)
    );

    // Normal: block normalize, square root, rounded divide, degenerate handling.
    bspn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (back_en),
        .i_valid (geo_valid),
        .i_pos   (geo_pos),
        .i_cross (geo_cross),
        .o_valid (o_valid),
        .o_pos   (out_pos),
        .o_norm  (out_norm),
        .o_degen (o_degenerate)
    );

    assign o_pos_x  = out_pos.x;
    assign o_pos_y  = out_pos.y;
    assign o_pos_z  = out_pos.z;
    assign o_norm_x = out_norm[0];
    assign o_norm_y = out_norm[1];
    assign o_norm_z = out_norm[2];

endmodule
